FILE: rtl/core/rct_pkg.sv
// Package for the command tokenizer: parse phases, result kinds, status codes,
// character constants and the result record types.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package rct_pkg;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_WORDS,
        PH_COUNT,
        PH_DOLLAR,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_TRAILER,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        DG_START,
        DG_SIGN,
        DG_DIGITS,
        DG_STOPPED
    } digit_state_t;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_TOK_END = 2'd1;
    localparam logic [1:0] KIND_CMD_END = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_DIGITS = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
    localparam logic [1:0] STATUS_NEGATIVE  = 2'd3;

    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;

    localparam logic [15:0] FIELD16_MAX = 16'hFFFF;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  token_byte;
        logic [15:0] token_index;
        logic [15:0] token_count;
        logic [1:0]  status;
    } rct_result_t;

    typedef struct packed {
        logic [1:0]                        count;
        rct_result_t [MAX_RESULTS-1:0]     slot;
    } rct_batch_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rct_step.sv
// Parser state and per-transfer step logic of the command tokenizer.
// Produces a batch of up to three results for each accepted transfer; uses rct_pkg.
`default_nettype none

module rct_step #(
    parameter int NUMBER_WIDTH      = 32,
    parameter int TOKEN_COUNT_WIDTH = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              byte_valid,
    input  wire logic              end_of_command,
    output rct_pkg::rct_batch_t    batch
);
    import rct_pkg::*;

    localparam int NW = NUMBER_WIDTH;
    localparam int TW = TOKEN_COUNT_WIDTH;
    localparam int CW = (TW > 16) ? TW : 16;

    phase_t          phase_reg,   phase_next;
    logic [NW-1:0]   acc_reg,     acc_next;
    logic            neg_reg,     neg_next;
    digit_state_t    dg_reg,      dg_next;
    logic            bad_reg,     bad_next;
    logic            cr_reg,      cr_next;
    logic [NW-1:0]   elems_reg,   elems_next;
    logic [NW-1:0]   payload_reg, payload_next;
    logic [1:0]      trail_reg,   trail_next;
    logic [TW-1:0]   tok_reg,     tok_next;
    logic            inside_reg,  inside_next;
    logic [1:0]      sticky_reg,  sticky_next;

    logic            emit_byte;
    logic            byte_finish;
    logic            end_finish;
    logic [TW-1:0]   tok_mid;
    logic [TW-1:0]   tok_final;
    logic [1:0]      status_final;

    logic            is_digit;
    logic [3:0]      digit_val;
    logic [NW+3:0]   mac;
    logic [NW-1:0]   acc_step;

    function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
        return (v == {TW{1'b1}}) ? v : v + TW'(1);
    endfunction

    function automatic logic [15:0] sat16(input logic [TW-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        return (w > CW'(FIELD16_MAX)) ? FIELD16_MAX : w[15:0];
    endfunction

    assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign digit_val = is_digit ? data_byte[3:0] : 4'd0;
    assign mac       = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + (NW+4)'(digit_val);
    assign acc_step  = (mac[NW+3:NW] != 4'd0) ? {NW{1'b1}} : mac[NW-1:0];

    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        dg_next      = dg_reg;
        bad_next     = bad_reg;
        cr_next      = cr_reg;
        elems_next   = elems_reg;
        payload_next = payload_reg;
        trail_next   = trail_reg;
        inside_next  = inside_reg;
        sticky_next  = sticky_reg;
        emit_byte    = 1'b0;
        byte_finish  = 1'b0;
        end_finish   = 1'b0;

        if (byte_valid) begin
            if (phase_reg == PH_FIRST && data_byte == CHAR_STAR) begin
                phase_next = PH_COUNT;
                acc_next   = '0;
                neg_next   = 1'b0;
                dg_next    = DG_START;
                bad_next   = 1'b0;
                cr_next    = 1'b0;
            end else begin
                if (phase_reg == PH_FIRST) begin
                    phase_next = PH_WORDS;
                end
                case (phase_next)
                    PH_WORDS: begin
                        if (is_space(data_byte)) begin
                            if (inside_reg) begin
                                byte_finish = 1'b1;
                                inside_next = 1'b0;
                            end
                        end else begin
                            emit_byte   = 1'b1;
                            inside_next = 1'b1;
                        end
                    end
                    PH_COUNT, PH_LENGTH: begin
                        if (cr_reg && data_byte == CHAR_LF) begin
                            cr_next = 1'b0;
                            if (bad_reg || dg_reg == DG_START || dg_reg == DG_SIGN) begin
                                if (sticky_next == STATUS_OK) begin
                                    sticky_next = STATUS_NO_DIGITS;
                                end
                                phase_next = PH_DONE;
                            end else if (neg_reg && acc_reg != '0) begin
                                if (sticky_next == STATUS_OK) begin
                                    sticky_next = STATUS_NEGATIVE;
                                end
                                phase_next = PH_DONE;
                            end else if (phase_reg == PH_COUNT) begin
                                elems_next = acc_reg;
                                phase_next = (acc_reg == '0) ? PH_DONE : PH_DOLLAR;
                            end else if (acc_reg == '0) begin
                                byte_finish = 1'b1;
                                trail_next  = 2'd2;
                                phase_next  = PH_TRAILER;
                            end else begin
                                payload_next = acc_reg;
                                phase_next   = PH_PAYLOAD;
                            end
                        end else begin
                            cr_next = (data_byte == CHAR_CR);
                            unique case (dg_reg)
                                DG_START: begin
                                    if (!is_space(data_byte)) begin
                                        if (data_byte == CHAR_MINUS) begin
                                            neg_next = 1'b1;
                                            dg_next  = DG_SIGN;
                                        end else if (data_byte == CHAR_PLUS) begin
                                            dg_next = DG_SIGN;
                                        end else if (is_digit) begin
                                            acc_next = NW'(digit_val);
                                            dg_next  = DG_DIGITS;
                                        end else begin
                                            bad_next = 1'b1;
                                            dg_next  = DG_STOPPED;
                                        end
                                    end
                                end
                                DG_SIGN: begin
                                    if (is_digit) begin
                                        acc_next = NW'(digit_val);
                                        dg_next  = DG_DIGITS;
                                    end else begin
                                        bad_next = 1'b1;
                                        dg_next  = DG_STOPPED;
                                    end
                                end
                                DG_DIGITS: begin
                                    if (is_digit) begin
                                        acc_next = acc_step;
                                    end else begin
                                        dg_next = DG_STOPPED;
                                    end
                                end
                                DG_STOPPED: begin
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                    PH_DOLLAR: begin
                        if (data_byte == CHAR_DOLLAR) begin
                            phase_next = PH_LENGTH;
                            acc_next   = '0;
                            neg_next   = 1'b0;
                            dg_next    = DG_START;
                            bad_next   = 1'b0;
                            cr_next    = 1'b0;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_PAYLOAD: begin
                        emit_byte = 1'b1;
                        if (payload_reg <= NW'(1)) begin
                            payload_next = '0;
                            byte_finish  = 1'b1;
                            trail_next   = 2'd2;
                            phase_next   = PH_TRAILER;
                        end else begin
                            payload_next = payload_reg - NW'(1);
                        end
                    end
                    PH_TRAILER: begin
                        if (trail_reg <= 2'd1) begin
                            trail_next = 2'd0;
                            if (elems_reg <= NW'(1)) begin
                                elems_next = '0;
                                phase_next = PH_DONE;
                            end else begin
                                elems_next = elems_reg - NW'(1);
                                phase_next = PH_DOLLAR;
                            end
                        end else begin
                            trail_next = trail_reg - 2'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        tok_mid   = byte_finish ? sat_inc(tok_reg) : tok_reg;
        tok_final = tok_mid;
        tok_next  = tok_mid;

        if (end_of_command) begin
            if (phase_next == PH_WORDS && inside_next) begin
                end_finish = 1'b1;
                tok_final  = sat_inc(tok_mid);
            end
            if (phase_next == PH_PAYLOAD && sticky_next == STATUS_OK) begin
                sticky_next = STATUS_TRUNCATED;
            end
        end
        status_final = sticky_next;

        if (end_of_command) begin
            phase_next   = PH_FIRST;
            acc_next     = '0;
            neg_next     = 1'b0;
            dg_next      = DG_START;
            bad_next     = 1'b0;
            cr_next      = 1'b0;
            elems_next   = '0;
            payload_next = '0;
            trail_next   = 2'd0;
            tok_next     = '0;
            inside_next  = 1'b0;
            sticky_next  = STATUS_OK;
        end
    end

    always_comb begin
        logic [1:0] n;
        n     = 2'd0;
        batch = '0;
        if (emit_byte) begin
            batch.slot[n].kind        = KIND_BYTE;
            batch.slot[n].token_byte  = data_byte;
            batch.slot[n].token_index = sat16(tok_reg);
            n = n + 2'd1;
        end
        if (byte_finish) begin
            batch.slot[n].kind        = KIND_TOK_END;
            batch.slot[n].token_index = sat16(tok_reg);
            n = n + 2'd1;
        end
        if (end_finish) begin
            batch.slot[n].kind        = KIND_TOK_END;
            batch.slot[n].token_index = sat16(tok_mid);
            n = n + 2'd1;
        end
        if (end_of_command) begin
            batch.slot[n].kind        = KIND_CMD_END;
            batch.slot[n].token_count = sat16(tok_final);
            batch.slot[n].status      = status_final;
            n = n + 2'd1;
        end
        batch.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FIRST;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            dg_reg      <= DG_START;
            bad_reg     <= 1'b0;
            cr_reg      <= 1'b0;
            elems_reg   <= '0;
            payload_reg <= '0;
            trail_reg   <= 2'd0;
            tok_reg     <= '0;
            inside_reg  <= 1'b0;
            sticky_reg  <= STATUS_OK;
        end else if (accept) begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            dg_reg      <= dg_next;
            bad_reg     <= bad_next;
            cr_reg      <= cr_next;
            elems_reg   <= elems_next;
            payload_reg <= payload_next;
            trail_reg   <= trail_next;
            tok_reg     <= tok_next;
            inside_reg  <= inside_next;
            sticky_reg  <= sticky_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rct_out_queue.sv
// Four-entry result queue of the command tokenizer, loaded with a whole batch per
// accepted input transfer and drained one result per output transfer; uses rct_pkg.
`default_nettype none

module rct_out_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire rct_pkg::rct_batch_t  batch,
    output logic                      room,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rct_pkg::rct_result_t      out_result
);
    import rct_pkg::*;

    localparam int DEPTH = 4;

    rct_result_t [DEPTH-1:0] q_reg, q_next;
    logic [2:0]              cnt_reg, cnt_next;
    logic                    pop;

    assign room       = (cnt_reg <= 3'd1);
    assign out_valid  = (cnt_reg != 3'd0);
    assign out_result = q_reg[0];
    assign pop        = out_valid && out_ready;

    always_comb begin
        logic [2:0] base;
        q_next = q_reg;
        base   = cnt_reg;
        if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                q_next[i] = q_reg[i+1];
            end
            base = cnt_reg - 3'd1;
        end
        cnt_next = base;
        if (push) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                if (2'(i) < batch.count) begin
                    q_next[2'(base + 3'(i))] = batch.slot[i];
                end
            end
            cnt_next = base + {1'b0, batch.count};
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        if (!aresetn) begin
            cnt_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/resp_command_tokenizer_top.sv
// Each result is written into the result queue and offered on the master side from
// there. Throughput: one input transfer per cycle while s_tready is high; an item that
// causes several results drains them one per cycle through the four-entry result queue
// while m_tready is high, and s_tready stays high while at most one result is queued.
// Reset: aresetn, synchronous and active low, clears the parser state and the queue.
// Depends on rct_pkg, rct_step and rct_out_queue.
`default_nettype none

module resp_command_tokenizer_top #(
    parameter int NUMBER_WIDTH      = 32,
    parameter int TOKEN_COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_command
    input  wire logic        s_tuser,   // [0] byte_valid
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] token_byte, [23:8] token_index,
                                        // [39:24] token_count, [41:40] status
    output logic [1:0]       m_tuser    // [1:0] kind
);
    import rct_pkg::*;

    logic        accept;
    rct_batch_t  batch;
    rct_result_t result;

    assign accept = s_tvalid && s_tready;

    rct_step #(
        .NUMBER_WIDTH      (NUMBER_WIDTH),
        .TOKEN_COUNT_WIDTH (TOKEN_COUNT_WIDTH)
    ) u_step (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .data_byte      (s_tdata),
        .byte_valid     (s_tuser),
        .end_of_command (s_tlast),
        .batch          (batch)
    );

    rct_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .batch      (batch),
        .room       (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {6'b0, result.status, result.token_count, result.token_index,
                      result.token_byte};
    assign m_tuser = result.kind;

endmodule

`default_nettype wire
